/* rtl/sdcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sdcp_pkg;

  // One packet byte and its end mark
  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } sdcp_in_t;

  // One parser result
  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] tsn;
    logic [15:0] sid;
    logic [15:0] stream_seq;
    logic [31:0] ppid;
    logic [7:0]  chunk_flags;
    logic [15:0] payload_length;
    logic [7:0]  payload_value;
    logic        chunk_end;
    logic        packet_end;
    logic        malformed;
  } sdcp_out_t;

  // Event codes
  localparam logic [1:0] EV_DESCRIPTOR = 2'd0;
  localparam logic [1:0] EV_PAYLOAD    = 2'd1;
  localparam logic [1:0] EV_PKT_END    = 2'd2;

  // Packet layout
  localparam logic [3:0]  COMMON_HEADER_BYTES = 4'd12;
  localparam logic [15:0] DATA_HEADER_BYTES   = 16'd16;
  localparam logic [15:0] MIN_CHUNK_BYTES     = 16'd4;
  localparam logic [7:0]  DATA_CHUNK_KIND     = 8'd0;

  // Byte offsets inside a chunk header
  localparam logic [15:0] OFF_TYPE       = 16'd0;
  localparam logic [15:0] OFF_FLAGS      = 16'd1;
  localparam logic [15:0] OFF_LEN_HI     = 16'd2;
  localparam logic [15:0] OFF_LEN_LO     = 16'd3;
  localparam logic [15:0] OFF_TSN_END    = 16'd7;
  localparam logic [15:0] OFF_STREAM_END = 16'd9;
  localparam logic [15:0] OFF_SEQ_END    = 16'd11;
  localparam logic [15:0] OFF_PROTO_END  = 16'd15;

  // Result queue between parser and output stage (depth a power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

endpackage

`default_nettype wire

/* rtl/sctp_data_chunk_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------
// input    | in_valid_i   | in_stall_o   | in_data_i  (sdcp_in_t)
// output   | out_valid_o  | out_stall_i  | out_data_o (sdcp_out_t)
//
// One packet byte per unstalled cycle; the parser updates its counters in the accepting cycle.
// A result passes through the result queue, then the output register, to reach out_valid_o.
// in_stall_o rises only when the two-entry result queue is full.
// Reset is asynchronous active low and clears parser state, queue and output valid.

module sctp_data_chunk_parser_unit import sdcp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire sdcp_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output sdcp_out_t      out_data_o
);

  logic      accept;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  sdcp_out_t front_result;
  sdcp_out_t q_data;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  sdcp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .result_o  (front_result)
  );

  sdcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_result),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  sdcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* rtl/sdcp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdcp_front import sdcp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire sdcp_in_t  in_data_i,
  output logic           push_o,
  output sdcp_out_t      result_o
);

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_CHUNKS  = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [3:0]  header_count_q, header_count_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] length_q, length_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] tsn_q, tsn_d;
  logic [15:0] stream_q, stream_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] proto_q, proto_d;

  logic [7:0]  byte_in;
  logic [3:0]  header_next;
  logic [15:0] len_cur;
  logic [16:0] off_p1;
  logic [16:0] padded;
  logic        is_data;
  logic        bad;
  logic        emit;

  assign byte_in     = in_data_i.packet_byte;
  assign header_next = header_count_q + 4'd1;
  assign len_cur     = (offset_q == OFF_LEN_LO) ? {length_q[15:8], byte_in} : length_q;
  assign off_p1      = {1'b0, offset_q} + 17'd1;
  assign padded      = ({1'b0, len_cur} + 17'd3) & ~17'd3;
  assign is_data     = (kind_q == DATA_CHUNK_KIND);

  // Byte classification and next state
  always_comb begin
    mode_d         = mode_q;
    header_count_d = header_count_q;
    offset_d       = offset_q;
    length_d       = length_q;
    kind_d         = kind_q;
    flags_d        = flags_q;
    tsn_d          = tsn_q;
    stream_d       = stream_q;
    seq_d          = seq_q;
    proto_d        = proto_q;
    result_o       = '0;
    emit           = 1'b0;
    bad            = 1'b0;

    unique case (mode_q)
      MODE_HEADER: begin
        if (header_next >= COMMON_HEADER_BYTES) begin
          header_count_d = COMMON_HEADER_BYTES;
          mode_d         = MODE_CHUNKS;
          offset_d       = '0;
        end else begin
          header_count_d = header_next;
        end
      end
      MODE_CHUNKS: begin
        // field capture by chunk offset
        if (offset_q == OFF_TYPE)             kind_d   = byte_in;
        else if (offset_q == OFF_FLAGS)       flags_d  = byte_in;
        else if (offset_q == OFF_LEN_HI)      length_d = {byte_in, 8'h00};
        else if (offset_q == OFF_LEN_LO)      length_d = len_cur;
        else if (offset_q <= OFF_TSN_END)     tsn_d    = {tsn_q[23:0], byte_in};
        else if (offset_q <= OFF_STREAM_END)  stream_d = {stream_q[7:0], byte_in};
        else if (offset_q <= OFF_SEQ_END)     seq_d    = {seq_q[7:0], byte_in};
        else if (offset_q <= OFF_PROTO_END)   proto_d  = {proto_q[23:0], byte_in};

        // length check once the length is complete
        if (offset_q == OFF_LEN_LO) begin
          bad = (len_cur < MIN_CHUNK_BYTES) || (is_data && (len_cur < DATA_HEADER_BYTES));
        end

        if (bad) begin
          mode_d = MODE_STOPPED;
        end else begin
          if (is_data && (offset_q == OFF_PROTO_END)) begin
            emit                    = 1'b1;
            result_o.event_res      = EV_DESCRIPTOR;
            result_o.tsn            = tsn_q;
            result_o.sid            = stream_q;
            result_o.stream_seq     = seq_q;
            result_o.ppid           = proto_d;
            result_o.chunk_flags    = flags_q;
            result_o.payload_length = len_cur - DATA_HEADER_BYTES;
            result_o.chunk_end      = (len_cur == DATA_HEADER_BYTES);
          end else if (is_data && (offset_q >= DATA_HEADER_BYTES) && (offset_q < len_cur)) begin
            emit                   = 1'b1;
            result_o.event_res     = EV_PAYLOAD;
            result_o.payload_value = byte_in;
            result_o.chunk_end     = (off_p1 == {1'b0, len_cur});
          end
          // wrap to the next chunk after the padding
          if ((offset_q >= OFF_LEN_LO) && (off_p1 >= padded)) offset_d = '0;
          else offset_d = off_p1[15:0];
        end
      end
      default: begin
        // stopped: ignore the rest of the packet
      end
    endcase

    // packet end: report and return to reset state
    if (in_data_i.last_byte) begin
      if (!emit) begin
        emit               = 1'b1;
        result_o.event_res = EV_PKT_END;
        result_o.malformed = (mode_d != MODE_HEADER) && (mode_d != MODE_CHUNKS);
      end
      result_o.packet_end = 1'b1;
      mode_d              = MODE_HEADER;
      header_count_d      = '0;
      offset_d            = '0;
      length_d            = '0;
      kind_d              = '0;
      flags_d             = '0;
      tsn_d               = '0;
      stream_d            = '0;
      seq_d               = '0;
      proto_d             = '0;
    end
  end

  assign push_o = accept_i && emit;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_HEADER;
      header_count_q <= '0;
      offset_q       <= '0;
      length_q       <= '0;
      kind_q         <= '0;
      flags_q        <= '0;
      tsn_q          <= '0;
      stream_q       <= '0;
      seq_q          <= '0;
      proto_q        <= '0;
    end else if (accept_i) begin
      mode_q         <= mode_d;
      header_count_q <= header_count_d;
      offset_q       <= offset_d;
      length_q       <= length_d;
      kind_q         <= kind_d;
      flags_q        <= flags_d;
      tsn_q          <= tsn_d;
      stream_q       <= stream_d;
      seq_q          <= seq_d;
      proto_q        <= proto_d;
    end
  end

  // A packet's last byte always yields a result and rearms the header count
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_data_i.last_byte) |-> push_o)
    else $error("last byte produced no result");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_data_i.last_byte) |=> (mode_q == MODE_HEADER) && (header_count_q == 4'd0))
    else $error("parser not rearmed after packet end");

endmodule

`default_nettype wire

/* rtl/sdcp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdcp_queue import sdcp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire sdcp_out_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output sdcp_out_t      data_o
);

  sdcp_out_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("result queue underflow");

endmodule

`default_nettype wire

/* rtl/sdcp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sdcp_back import sdcp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  input  wire sdcp_out_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output sdcp_out_t      out_data_o
);

  logic      valid_q;
  sdcp_out_t data_q;
  logic      load;

  // Refill the output register when empty or when its item leaves
  assign load  = q_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= q_data_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // A stalled result is never replaced
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !pop_o)
    else $error("output overwritten while stalled");

endmodule

`default_nettype wire
